### rtl/core/mqtt_control_packet_parser_defines.svh
// Assertion helpers for the parser modules (included by mcpp_back).
`ifndef MQTT_CONTROL_PACKET_PARSER_DEFINES_SVH
`define MQTT_CONTROL_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define MCPP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcpp assertion failed");

// Next-cycle implication, disabled while reset is active.
`define MCPP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcpp assertion failed");

`endif

### rtl/core/mcpp_pkg.sv
package mcpp_pkg;

    typedef logic [4:0] field_t;

    localparam field_t FLD_HDR       = 5'd0;
    localparam field_t FLD_REMLEN    = 5'd1;
    localparam field_t FLD_PROTO_LEN = 5'd2;
    localparam field_t FLD_VERSION   = 5'd4;
    localparam field_t FLD_FLAGS     = 5'd5;
    localparam field_t FLD_KEEPALIVE = 5'd6;
    localparam field_t FLD_CLIENT    = 5'd7;
    localparam field_t FLD_WTOPIC    = 5'd9;
    localparam field_t FLD_WMSG      = 5'd11;
    localparam field_t FLD_USER      = 5'd13;
    localparam field_t FLD_PASS      = 5'd15;
    localparam field_t FLD_CONNACK   = 5'd17;
    localparam field_t FLD_TOPIC     = 5'd18;
    localparam field_t FLD_MSGID     = 5'd20;

    typedef logic [1:0] err_t;

    localparam err_t ERR_NONE   = 2'd0;
    localparam err_t ERR_REMLEN = 2'd1;
    localparam err_t ERR_TYPE   = 2'd2;

    localparam int unsigned VALUE_W = 28;

    typedef enum logic [2:0] {
        KC_BAD     = 3'd0,
        KC_CONNECT = 3'd1,
        KC_CONNACK = 3'd2,
        KC_PUBLISH = 3'd3,
        KC_ACK     = 3'd4
    } kind_class_t;

    typedef enum logic [2:0] {
        STR_PROTO  = 3'd0,
        STR_CLIENT = 3'd1,
        STR_WTOPIC = 3'd2,
        STR_WMSG   = 3'd3,
        STR_USER   = 3'd4,
        STR_PASS   = 3'd5,
        STR_TOPIC  = 3'd6
    } str_sel_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [6:0]  low7;
        logic        cont;
        kind_class_t kind;
        logic [2:0]  opt;
    } front_item_t;

    typedef struct packed {
        field_t               field;
        logic [7:0]           data_byte;
        logic [VALUE_W-1:0]   value;
        logic                 value_done;
        logic                 packet_done;
        err_t                 error_code;
    } result_t;

    function automatic field_t str_len_field(input str_sel_t sel);
        field_t f;
        case (sel)
            STR_PROTO:  f = FLD_PROTO_LEN;
            STR_CLIENT: f = FLD_CLIENT;
            STR_WTOPIC: f = FLD_WTOPIC;
            STR_WMSG:   f = FLD_WMSG;
            STR_USER:   f = FLD_USER;
            STR_PASS:   f = FLD_PASS;
            STR_TOPIC:  f = FLD_TOPIC;
            default:    f = FLD_PASS;
        endcase
        return f;
    endfunction

endpackage

### rtl/core/mcpp_front.sv
module mcpp_front import mcpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        f_valid,
    input  logic        f_ready,
    output front_item_t f_item
);

    logic        valid_reg;
    front_item_t item_reg;
    front_item_t item_next;
    logic        advance;

    assign advance = !valid_reg || f_ready;
    assign s_ready = advance;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        item_next.rx_byte = s_rx_byte;
        item_next.low7    = s_rx_byte[6:0];
        item_next.cont    = s_rx_byte[7];
        item_next.opt     = {s_rx_byte[6], s_rx_byte[7], s_rx_byte[2]};
        case (s_rx_byte[7:4])
            4'd1:    item_next.kind = KC_CONNECT;
            4'd2:    item_next.kind = KC_CONNACK;
            4'd3:    item_next.kind = KC_PUBLISH;
            4'd4, 4'd5, 4'd6, 4'd7: item_next.kind = KC_ACK;
            default: item_next.kind = KC_BAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/core/mcpp_queue.sv
module mcpp_queue import mcpp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    front_item_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != FULL;
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/mcpp_back.sv
`include "mqtt_control_packet_parser_defines.svh"

module mcpp_back import mcpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  front_item_t q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_item
);

    typedef enum logic [8:0] {
        S_HDR       = 9'b000000001,
        S_REMLEN    = 9'b000000010,
        S_VERSION   = 9'b000000100,
        S_FLAGS     = 9'b000001000,
        S_KEEPALIVE = 9'b000010000,
        S_CONNACK   = 9'b000100000,
        S_MSGID     = 9'b001000000,
        S_STRLEN    = 9'b010000000,
        S_STRBODY   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    str_sel_t            sel_reg, sel_next;
    kind_class_t         kind_reg, kind_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [15:0]         left_reg, left_next;
    logic [7:0]          hold_reg, hold_next;
    logic [2:0]          flags_reg, flags_next;
    logic                second_reg, second_next;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             res;
    logic                pop;
    logic [1:0]          n;
    logic [4:0]          shamt;
    logic [15:0]         len16;
    logic [15:0]         left_dec;
    state_t              as_state;
    str_sel_t            as_sel;
    logic                as_done;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign q_ready   = pop;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign n        = cnt_reg[1:0];
    assign shamt    = ({3'b000, n} << 3) - {3'b000, n};
    assign len16    = {hold_reg, q_item.rx_byte};
    assign left_dec = left_reg - 16'd1;

    // Where the parse goes once the current string is finished.
    always_comb begin
        as_state = S_STRLEN;
        as_sel   = sel_reg;
        as_done  = 1'b0;
        case (sel_reg)
            STR_PROTO:  as_state = S_VERSION;
            STR_TOPIC:  as_state = S_MSGID;
            STR_WTOPIC: as_sel = STR_WMSG;
            STR_CLIENT: begin
                if (flags_reg[0]) begin
                    as_sel = STR_WTOPIC;
                end else if (flags_reg[1]) begin
                    as_sel = STR_USER;
                end else if (flags_reg[2]) begin
                    as_sel = STR_PASS;
                end else begin
                    as_done = 1'b1;
                end
            end
            STR_WMSG: begin
                if (flags_reg[1]) begin
                    as_sel = STR_USER;
                end else if (flags_reg[2]) begin
                    as_sel = STR_PASS;
                end else begin
                    as_done = 1'b1;
                end
            end
            STR_USER: begin
                if (flags_reg[2]) begin
                    as_sel = STR_PASS;
                end else begin
                    as_done = 1'b1;
                end
            end
            default: as_done = 1'b1;
        endcase
        if (as_done) begin
            as_state = S_HDR;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        kind_next   = kind_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        hold_next   = hold_reg;
        flags_next  = flags_reg;
        second_next = second_reg;

        res.field       = FLD_HDR;
        res.data_byte   = q_item.rx_byte;
        res.value       = '0;
        res.value_done  = 1'b0;
        res.packet_done = 1'b0;
        res.error_code  = ERR_NONE;

        case (state_reg)
            S_HDR: begin
                kind_next      = q_item.kind;
                acc_next       = '0;
                cnt_next       = '0;
                second_next    = 1'b0;
                flags_next     = '0;
                res.value      = VALUE_W'(q_item.rx_byte);
                res.value_done = 1'b1;
                state_next     = S_REMLEN;
            end
            S_REMLEN: begin
                res.field = FLD_REMLEN;
                acc_next  = acc_reg + (VALUE_W'(q_item.low7) << shamt);
                cnt_next  = {1'b0, n} + 3'd1;
                if (q_item.cont) begin
                    if (n == 2'd3) begin
                        res.error_code = ERR_REMLEN;
                        state_next     = S_HDR;
                    end
                end else begin
                    res.value      = acc_next;
                    res.value_done = 1'b1;
                    second_next    = 1'b0;
                    case (kind_reg)
                        KC_CONNECT: begin
                            state_next = S_STRLEN;
                            sel_next   = STR_PROTO;
                        end
                        KC_CONNACK: state_next = S_CONNACK;
                        KC_PUBLISH: begin
                            state_next = S_STRLEN;
                            sel_next   = STR_TOPIC;
                        end
                        KC_ACK:     state_next = S_MSGID;
                        default: begin
                            res.error_code = ERR_TYPE;
                            state_next     = S_HDR;
                        end
                    endcase
                end
            end
            S_VERSION: begin
                res.field      = FLD_VERSION;
                res.value      = VALUE_W'(q_item.rx_byte);
                res.value_done = 1'b1;
                state_next     = S_FLAGS;
            end
            S_FLAGS: begin
                res.field      = FLD_FLAGS;
                flags_next     = q_item.opt;
                res.value      = VALUE_W'(q_item.rx_byte);
                res.value_done = 1'b1;
                second_next    = 1'b0;
                state_next     = S_KEEPALIVE;
            end
            S_KEEPALIVE, S_MSGID: begin
                res.field = (state_reg == S_MSGID) ? FLD_MSGID : FLD_KEEPALIVE;
                if (!second_reg) begin
                    hold_next   = q_item.rx_byte;
                    second_next = 1'b1;
                end else begin
                    res.value      = VALUE_W'(len16);
                    res.value_done = 1'b1;
                    second_next    = 1'b0;
                    if (state_reg == S_KEEPALIVE) begin
                        state_next = S_STRLEN;
                        sel_next   = STR_CLIENT;
                    end else begin
                        state_next      = S_HDR;
                        res.packet_done = 1'b1;
                    end
                end
            end
            S_CONNACK: begin
                res.field      = FLD_CONNACK;
                res.value      = VALUE_W'(q_item.rx_byte);
                res.value_done = 1'b1;
                if (!second_reg) begin
                    second_next = 1'b1;
                end else begin
                    second_next     = 1'b0;
                    state_next      = S_HDR;
                    res.packet_done = 1'b1;
                end
            end
            S_STRLEN: begin
                res.field = str_len_field(sel_reg);
                if (!second_reg) begin
                    hold_next   = q_item.rx_byte;
                    second_next = 1'b1;
                end else begin
                    res.value      = VALUE_W'(len16);
                    res.value_done = 1'b1;
                    second_next    = 1'b0;
                    if (len16 == '0) begin
                        state_next      = as_state;
                        sel_next        = as_sel;
                        res.packet_done = as_done;
                    end else begin
                        left_next  = len16;
                        state_next = S_STRBODY;
                    end
                end
            end
            S_STRBODY: begin
                res.field = str_len_field(sel_reg) + 5'd1;
                left_next = left_dec;
                if (left_dec == '0) begin
                    state_next      = as_state;
                    sel_next        = as_sel;
                    res.packet_done = as_done;
                end
            end
            default: begin
                state_next = S_HDR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_HDR;
            sel_reg    <= STR_PROTO;
            kind_reg   <= KC_BAD;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            left_reg   <= '0;
            hold_reg   <= '0;
            flags_reg  <= '0;
            second_reg <= 1'b0;
        end else if (pop) begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            kind_reg   <= kind_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            hold_reg   <= hold_next;
            flags_reg  <= flags_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= res;
        end
    end

    `MCPP_ASSERT_IMP(a_err_only_on_remlen, aclk, aresetn, out_valid_reg && out_reg.error_code != ERR_NONE, out_reg.field == FLD_REMLEN)
    `MCPP_ASSERT_IMP(a_value_zero_unless_done, aclk, aresetn, out_valid_reg && !out_reg.value_done, out_reg.value == '0)
    `MCPP_ASSERT_NXT(a_end_returns_to_hdr, aclk, aresetn, pop && (res.packet_done || res.error_code != ERR_NONE), state_reg == S_HDR)

endmodule

### rtl/core/mqtt_control_packet_parser.sv
// MQTT control packet parser.
// The input channel (s_valid, s_ready, s_rx_byte) takes the byte stream one
// item per cycle while s_ready is high. For every byte taken, the result
// channel (m_valid, m_ready) delivers exactly one item that tags the byte
// with its field code, echoes it, and reports a decoded numeric value, a
// packet end flag and an error code. A classifying front stage feeds a small
// queue, and the parser state machine behind the queue writes a result
// register. A byte passes through the front register, the queue and the
// result register. Throughput is one item per cycle while m_ready stays high,
// set by the single state update the parser does for each byte.
// After reset the parser waits for a fixed header byte and the queue is
// empty. When the receiver stalls, the result register holds, the queue
// fills up to QUEUE_DEPTH items, the front register holds one more, and then
// s_ready drops until the receiver takes results again; no item is lost.
module mqtt_control_packet_parser import mcpp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_rx_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [4:0]   m_field,
    output logic [7:0]   m_data_byte,
    output logic [27:0]  m_value,
    output logic         m_value_done,
    output logic         m_packet_done,
    output logic [1:0]   m_error_code
);

    logic        f_valid, f_ready;
    front_item_t f_item;
    logic        q_valid, q_ready;
    front_item_t q_item;
    result_t     res;

    mcpp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .f_valid   (f_valid),
        .f_ready   (f_ready),
        .f_item    (f_item)
    );

    mcpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    mcpp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (res)
    );

    assign m_field       = res.field;
    assign m_data_byte   = res.data_byte;
    assign m_value       = res.value;
    assign m_value_done  = res.value_done;
    assign m_packet_done = res.packet_done;
    assign m_error_code  = res.error_code;

endmodule

### tb/mqtt_control_packet_parser_tb.sv
module mqtt_control_packet_parser_tb;
    import mcpp_pkg::*;

    localparam logic [3:0] PKT_RESERVED = 4'd0;
    localparam logic [3:0] PKT_CONNECT = 4'd1;
    localparam logic [3:0] PKT_CONNACK = 4'd2;
    localparam logic [3:0] PKT_PUBLISH = 4'd3;
    localparam logic [3:0] PKT_PUBACK = 4'd4;
    localparam logic [3:0] PKT_PUBCOMP = 4'd7;
    localparam logic [3:0] PKT_SUBSCRIBE = 4'd8;

    localparam int FLAG_WILL_BIT = 2;
    localparam int FLAG_PASS_BIT = 6;
    localparam int FLAG_USER_BIT = 7;

    localparam int ITEMS_PER_PHASE = 317;
    localparam int STALL_LIMIT = 2000;

    class field_tagger_model;
        result_t expected_tags[$];
        int mismatches;
        field_t cur_state;
        logic [3:0] pkt_type;
        logic [27:0] len_acc;
        logic [2:0] len_bytes;
        logic [15:0] str_left;
        logic [7:0] hi_byte;
        logic [2:0] opt_present;
        logic want_low;

        function new();
            mismatches = 0;
            cur_state = FLD_HDR;
            pkt_type = '0;
            len_acc = '0;
            len_bytes = '0;
            str_left = '0;
            hi_byte = '0;
            opt_present = '0;
            want_low = 1'b0;
        endfunction

        function int tags_outstanding();
            return expected_tags.size();
        endfunction

        // The optional strings are kept as bit 0 will, bit 1 username, bit 2 password.
        function field_t after_string(field_t len_code, output logic ends);
            ends = 1'b0;
            case (len_code)
                FLD_PROTO_LEN: return FLD_VERSION;
                FLD_TOPIC: return FLD_MSGID;
                FLD_CLIENT: begin
                    if (opt_present[0]) return FLD_WTOPIC;
                    if (opt_present[1]) return FLD_USER;
                    if (opt_present[2]) return FLD_PASS;
                end
                FLD_WTOPIC: return FLD_WMSG;
                FLD_WMSG: begin
                    if (opt_present[1]) return FLD_USER;
                    if (opt_present[2]) return FLD_PASS;
                end
                FLD_USER: begin
                    if (opt_present[2]) return FLD_PASS;
                end
                default: ;
            endcase
            ends = 1'b1;
            return FLD_HDR;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t r;
            field_t st;
            logic [1:0] n;
            logic [15:0] len;
            logic ends;
            r = '0;
            ends = 1'b0;
            r.data_byte = b;
            st = (cur_state > FLD_MSGID) ? FLD_HDR : cur_state;
            r.field = st;
            case (st)
                FLD_HDR: begin
                    pkt_type = b[7:4];
                    len_acc = '0;
                    len_bytes = '0;
                    want_low = 1'b0;
                    opt_present = '0;
                    r.value = 28'(b);
                    r.value_done = 1'b1;
                    cur_state = FLD_REMLEN;
                end
                FLD_REMLEN: begin
                    n = len_bytes[1:0];
                    len_acc = len_acc + (28'(b[6:0]) << (7 * n));
                    len_bytes = {1'b0, n} + 3'd1;
                    if (b[7]) begin
                        if (len_bytes >= 3'd4) begin
                            r.error_code = ERR_REMLEN;
                            cur_state = FLD_HDR;
                        end
                    end else begin
                        r.value = len_acc;
                        r.value_done = 1'b1;
                        if (pkt_type == PKT_CONNECT) begin
                            cur_state = FLD_PROTO_LEN;
                        end else if (pkt_type == PKT_CONNACK) begin
                            cur_state = FLD_CONNACK;
                        end else if (pkt_type == PKT_PUBLISH) begin
                            cur_state = FLD_TOPIC;
                        end else if (pkt_type >= PKT_PUBACK && pkt_type <= PKT_PUBCOMP) begin
                            cur_state = FLD_MSGID;
                        end else begin
                            r.error_code = ERR_TYPE;
                            cur_state = FLD_HDR;
                        end
                        want_low = 1'b0;
                    end
                end
                FLD_VERSION: begin
                    r.value = 28'(b);
                    r.value_done = 1'b1;
                    cur_state = FLD_FLAGS;
                end
                FLD_FLAGS: begin
                    opt_present = {b[FLAG_PASS_BIT], b[FLAG_USER_BIT], b[FLAG_WILL_BIT]};
                    r.value = 28'(b);
                    r.value_done = 1'b1;
                    cur_state = FLD_KEEPALIVE;
                    want_low = 1'b0;
                end
                FLD_KEEPALIVE, FLD_MSGID: begin
                    if (!want_low) begin
                        hi_byte = b;
                        want_low = 1'b1;
                    end else begin
                        r.value = 28'({hi_byte, b});
                        r.value_done = 1'b1;
                        want_low = 1'b0;
                        if (st == FLD_KEEPALIVE) begin
                            cur_state = FLD_CLIENT;
                        end else begin
                            cur_state = FLD_HDR;
                            ends = 1'b1;
                        end
                    end
                end
                FLD_CONNACK: begin
                    r.value = 28'(b);
                    r.value_done = 1'b1;
                    if (!want_low) begin
                        want_low = 1'b1;
                    end else begin
                        want_low = 1'b0;
                        cur_state = FLD_HDR;
                        ends = 1'b1;
                    end
                end
                FLD_PROTO_LEN, FLD_CLIENT, FLD_WTOPIC, FLD_WMSG, FLD_USER, FLD_PASS,
                FLD_TOPIC: begin
                    if (!want_low) begin
                        hi_byte = b;
                        want_low = 1'b1;
                    end else begin
                        len = {hi_byte, b};
                        r.value = 28'(len);
                        r.value_done = 1'b1;
                        want_low = 1'b0;
                        if (len == 16'd0) begin
                            cur_state = after_string(st, ends);
                        end else begin
                            str_left = len;
                            cur_state = st + 5'd1;
                        end
                    end
                end
                default: begin
                    str_left = str_left - 16'd1;
                    if (str_left == 16'd0) begin
                        cur_state = after_string(st - 5'd1, ends);
                    end
                end
            endcase
            r.packet_done = ends;
            expected_tags.push_back(r);
        endfunction

        function void check_tag(result_t got);
            result_t exp_tag;
            if (expected_tags.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: field %0d byte %02h value %0h", got.field,
                             got.data_byte, got.value);
                end
                return;
            end
            exp_tag = expected_tags.pop_front();
            if (got.field !== exp_tag.field || got.data_byte !== exp_tag.data_byte ||
                got.value !== exp_tag.value || got.value_done !== exp_tag.value_done ||
                got.packet_done !== exp_tag.packet_done ||
                got.error_code !== exp_tag.error_code) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected field %0d byte %02h value %0h vd %b pd %b err %0d",
                             exp_tag.field, exp_tag.data_byte, exp_tag.value,
                             exp_tag.value_done, exp_tag.packet_done, exp_tag.error_code);
                    $display("          actual   field %0d byte %02h value %0h vd %b pd %b err %0d",
                             got.field, got.data_byte, got.value, got.value_done,
                             got.packet_done, got.error_code);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [4:0] m_field;
    logic [7:0] m_data_byte;
    logic [27:0] m_value;
    logic m_value_done;
    logic m_packet_done;
    logic [1:0] m_error_code;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;

    field_tagger_model tagger = new();

    mqtt_control_packet_parser dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_field(m_field),
        .m_data_byte(m_data_byte),
        .m_value(m_value),
        .m_value_done(m_value_done),
        .m_packet_done(m_packet_done),
        .m_error_code(m_error_code)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tagger.check_tag({m_field, m_data_byte, m_value, m_value_done,
                                  m_packet_done, m_error_code});
            end
            if (s_valid && s_ready) begin
                tagger.note_byte(s_rx_byte);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[mqtt_control_packet_parser] ERROR");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic send_u16(input logic [15:0] v);
        send_byte(v[15:8]);
        send_byte(v[7:0]);
    endtask

    task automatic send_header(input logic [3:0] kind);
        send_byte({kind, 4'($urandom_range(0, 15))});
    endtask

    task automatic send_remlen();
        int nbytes;
        int i;
        logic [7:0] b;
        nbytes = $urandom_range(1, 4);
        for (i = 0; i < nbytes; i++) begin
            b = 8'($urandom_range(0, 127));
            b[7] = (i < nbytes - 1);
            send_byte(b);
        end
    endtask

    task automatic send_string();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            len = 0;
        end else if (r < 80) begin
            len = $urandom_range(1, 5);
        end else if (r < 97) begin
            len = $urandom_range(6, 24);
        end else begin
            len = $urandom_range(256, 263);
        end
        send_u16(16'(len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_connect();
        logic [7:0] flags;
        flags = 8'($urandom_range(0, 255));
        send_header(PKT_CONNECT);
        send_remlen();
        send_string();
        send_byte(8'($urandom_range(0, 255)));
        send_byte(flags);
        send_u16(16'($urandom_range(0, 65535)));
        send_string();
        if (flags[FLAG_WILL_BIT]) begin
            send_string();
            send_string();
        end
        if (flags[FLAG_USER_BIT]) send_string();
        if (flags[FLAG_PASS_BIT]) send_string();
    endtask

    // Random bytes from a header on, with string length high bytes held at zero
    // so that no body runs longer than 255 bytes.
    task automatic send_noise(input int n);
        int k;
        logic [7:0] b;
        for (k = 0; k < n || tagger.cur_state != FLD_HDR; k++) begin
            b = 8'($urandom_range(0, 255));
            if (!tagger.want_low && tagger.cur_state inside {FLD_PROTO_LEN, FLD_CLIENT,
                FLD_WTOPIC, FLD_WMSG, FLD_USER, FLD_PASS, FLD_TOPIC}) begin
                b = 8'h00;
            end
            send_byte(b);
        end
    endtask

    task automatic send_random_packet();
        int r;
        int k;
        logic [3:0] kind;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_connect();
        end else if (r < 45) begin
            send_header(PKT_CONNACK);
            send_remlen();
            send_u16(16'($urandom_range(0, 65535)));
        end else if (r < 65) begin
            send_header(PKT_PUBLISH);
            send_remlen();
            send_string();
            send_u16(16'($urandom_range(0, 65535)));
        end else if (r < 80) begin
            send_header(4'($urandom_range(PKT_PUBACK, PKT_PUBCOMP)));
            send_remlen();
            send_u16(16'($urandom_range(0, 65535)));
        end else if (r < 87) begin
            kind = 4'($urandom_range(PKT_SUBSCRIBE - 1, 15));
            send_header((kind < PKT_SUBSCRIBE) ? PKT_RESERVED : kind);
            send_remlen();
        end else if (r < 92) begin
            send_byte(8'($urandom_range(0, 255)));
            for (k = 0; k < 4; k++) send_byte({1'b1, 7'($urandom_range(0, 127))});
        end else begin
            send_noise($urandom_range(1, 8));
        end
    endtask

    initial begin : stimulus
        int ph;
        int i;
        logic [7:0] directed_bytes[29];
        directed_bytes = '{
            {PKT_PUBACK, 4'h0}, 8'h00, 8'h00, 8'h00,
            {PKT_PUBLISH, 4'hF}, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            {4'hF, 4'h0}, 8'h00,
            {PKT_CONNECT, 4'h0}, 8'h00, 8'h00, 8'h00, 8'h04, 8'hC4, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
        };
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 77 : 0;
            recv_stall_pct = (ph == 0) ? 77 : (ph == 1) ? 7 : 0;
            if (ph == 0) begin
                for (i = 0; i < 29; i++) send_byte(directed_bytes[i]);
            end
            while (bytes_sent < (ph + 1) * ITEMS_PER_PHASE) send_random_packet();
            s_valid <= 1'b0;
            @(negedge aclk);
            while (tagger.tags_outstanding() != 0) @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (tagger.mismatches == 0 && tagger.tags_outstanding() == 0) begin
            $display("[mqtt_control_packet_parser] OK");
        end else begin
            $display("[mqtt_control_packet_parser] ERROR");
        end
        $finish;
    end

endmodule
